// ===== hdl/byte_stuffed_frame_receiver_assert.svh =====
// assertion macros for the byte stuffed frame receiver
// no dependencies; included inside module bodies that check their own logic
`ifndef BYTE_STUFFED_FRAME_RECEIVER_ASSERT_SVH
`define BYTE_STUFFED_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BSFR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bsfr check failed");

// next-cycle implication, disabled while in reset
`define BSFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bsfr check failed");

`endif

// ===== hdl/bsfr_pkg.sv =====
// shared types and constants for the byte stuffed frame receiver
// no dependencies
`default_nettype none

package bsfr_pkg;

   localparam logic [7:0] ESC_BYTE   = 8'h7E;
   localparam logic [7:0] START_BYTE = 8'hA5;
   localparam logic [7:0] END_BYTE   = 8'hA6;

   localparam logic [7:0] CAPACITY_RESET = 8'd64;

   typedef enum logic [1:0] {
      EV_PAYLOAD = 2'd0,
      EV_VALID   = 2'd1,
      EV_INVALID = 2'd2
   } event_kind_type;

   typedef struct packed {
      event_kind_type kind;
      logic [7:0]     value;
      logic [7:0]     index;
   } result_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } stage_type;

endpackage

`default_nettype wire

// ===== hdl/bsfr_input_reg.sv =====
// input register stage: holds one received byte until the decoder takes it
// depends on bsfr_pkg
`default_nettype none

module bsfr_input_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [7:0]        req_byte_in,
   input  wire logic              advance,
   output bsfr_pkg::stage_type    stage
);
   import bsfr_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       req_fire;

   assign req_ready = !valid_ff || advance;
   assign req_fire  = req_valid && req_ready;
   assign valid_in  = req_fire || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         byte_ff <= req_byte_in;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.data  = byte_ff;

endmodule

`default_nettype wire

// ===== hdl/bsfr_decoder.sv =====
// receive phase machine and write position counter, one byte per advance
// depends on bsfr_pkg and the assertion macro header
`default_nettype none

module bsfr_decoder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        capacity,
   input  wire logic [7:0]        byte_in,
   input  wire logic              advance,
   output logic                   result_valid,
   output bsfr_pkg::result_type   result
);
   import bsfr_pkg::*;
   `include "byte_stuffed_frame_receiver_assert.svh"

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_SEARCH  = 3'd1,
      PH_START   = 3'd2,
      PH_ESCAPED = 3'd3,
      PH_DATA    = 3'd4,
      PH_END     = 3'd5
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] pos_ff, pos_in;
   logic       has_room;

   assign has_room = pos_ff < capacity;

   always_comb begin
      phase_in     = phase_ff;
      pos_in       = pos_ff;
      result_valid = 1'b0;
      result       = '0;
      case (phase_ff)
         PH_SEARCH: begin
            if (byte_in == START_BYTE) begin
               phase_in = PH_START;
               pos_in   = '0;
            end else if (byte_in == ESC_BYTE) begin
               phase_in = PH_SEARCH;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_START, PH_DATA: begin
            if (byte_in == ESC_BYTE) begin
               phase_in = PH_ESCAPED;
            end else begin
               phase_in = PH_DATA;
               if (has_room) begin
                  pos_in       = pos_ff + 8'd1;
                  result_valid = 1'b1;
                  result.kind  = EV_PAYLOAD;
                  result.value = byte_in;
                  result.index = pos_ff;
               end
            end
         end
         PH_ESCAPED: begin
            if (byte_in == START_BYTE) begin
               phase_in = PH_START;
               pos_in   = '0;
            end else if (byte_in == END_BYTE) begin
               phase_in     = PH_END;
               result_valid = 1'b1;
               result.kind  = EV_VALID;
               result.index = pos_ff;
            end else if (byte_in == ESC_BYTE) begin
               phase_in = PH_DATA;
               if (has_room) begin
                  pos_in       = pos_ff + 8'd1;
                  result_valid = 1'b1;
                  result.kind  = EV_PAYLOAD;
                  result.value = byte_in;
                  result.index = pos_ff;
               end
            end else begin
               phase_in     = PH_IDLE;
               result_valid = 1'b1;
               result.kind  = EV_INVALID;
               result.index = pos_ff;
            end
         end
         default: begin
            // idle and end behave alike
            phase_in = (byte_in == ESC_BYTE) ? PH_SEARCH : PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff   <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
      end
   end

   `BSFR_ASSERT_IMPLY(a_payload_in_range, clock, reset,
      result_valid && result.kind == EV_PAYLOAD, result.index < capacity)
   `BSFR_ASSERT_IMPLY(a_event_value_zero, clock, reset,
      result_valid && result.kind != EV_PAYLOAD, result.value == 8'd0)
   `BSFR_ASSERT_IMPLY(a_start_pos_clear, clock, reset,
      phase_ff == PH_START, pos_ff == 8'd0)
   `BSFR_ASSERT_NEXT(a_payload_counts, clock, reset,
      advance && result_valid && result.kind == EV_PAYLOAD,
      pos_ff == $past(pos_ff) + 8'd1)

endmodule

`default_nettype wire

// ===== hdl/bsfr_output_reg.sv =====
// result register: holds one result until the consumer takes it
// depends on bsfr_pkg
`default_nettype none

module bsfr_output_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              load,
   input  wire bsfr_pkg::result_type result,
   output logic                   slot_free,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [1:0]             rsp_event_kind,
   output logic [7:0]             rsp_byte_value,
   output logic [7:0]             rsp_byte_index
);
   import bsfr_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign slot_free = !valid_ff || rsp_ready;
   assign valid_in  = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_event_kind = data_ff.kind;
   assign rsp_byte_value = data_ff.value;
   assign rsp_byte_index = data_ff.index;

endmodule

`default_nettype wire

// ===== hdl/byte_stuffed_frame_receiver.sv =====
// a request accepted into the input register passes through the decoder into the
// result register, where its result stays on rsp until the consumer takes it
// throughput: one request per cycle, set by the single pass through the phase machine,
// while the result slot is free; a request with no result simply leaves the pipe
// after the decoder step; reset (synchronous, active high) empties both stages,
// returns to idle phase, clears the write position and loads payload_capacity with 64
`default_nettype none

module byte_stuffed_frame_receiver (
   input  wire logic       clock,
   input  wire logic       reset,
   // received byte requests
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_byte_in,
   // frame events and payload bytes
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [1:0]      rsp_event_kind,
   output logic [7:0]      rsp_byte_value,
   output logic [7:0]      rsp_byte_index,
   // capacity register write
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [7:0] csr_payload_capacity
);
   import bsfr_pkg::*;

   logic       [7:0] capacity_ff;
   stage_type        stage;
   logic             slot_free;
   logic             advance;
   logic             result_valid;
   result_type       result;

   // capacity register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_valid) begin
         capacity_ff <= csr_payload_capacity;
      end
   end

   // a held byte moves through the decoder only when the result slot can
   // take whatever it produces
   assign advance = stage.valid && slot_free;

   bsfr_input_reg u_input (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_byte_in (req_byte_in),
      .advance     (advance),
      .stage       (stage)
   );

   // phase machine and write position, state commits on advance
   bsfr_decoder u_decoder (
      .clock        (clock),
      .reset        (reset),
      .capacity     (capacity_ff),
      .byte_in      (stage.data),
      .advance      (advance),
      .result_valid (result_valid),
      .result       (result)
   );

   // result register parts the consumer from the decoder
   bsfr_output_reg u_output (
      .clock          (clock),
      .reset          (reset),
      .load           (advance && result_valid),
      .result         (result),
      .slot_free      (slot_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_kind (rsp_event_kind),
      .rsp_byte_value (rsp_byte_value),
      .rsp_byte_index (rsp_byte_index)
   );

endmodule

`default_nettype wire
